### hw/rtl/tvi_pkg.sv
// Shared types and constants for the timestamped velocity interpolator.
// No dependencies; imported by the interfaces, the interpolator and the scaling lane.
`default_nettype none

package tvi_pkg;

  localparam int STAMP_W   = 48;
  localparam int COMP_W    = 32;
  localparam int NCOMP     = 6;
  localparam int DEPTH_DEF = 16;
  localparam int CHUNK_W   = 16;
  localparam int PROD_W    = COMP_W + 1 + STAMP_W;
  localparam int Q_W       = 42;
  localparam int SUM_W     = Q_W + 1;

  // Magnitude limit of the scaled term: 2^40.
  localparam logic [Q_W-2:0] Q_LIMIT = {1'b1, {(Q_W-2){1'b0}}};

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_HOLD   = 2'd1;
  localparam logic [1:0] ST_EXTRAP = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [STAMP_W-1:0]    stamp;
    comp_t [NCOMP-1:0]     vel;
  } sample_t;

endpackage

`default_nettype wire

### hw/rtl/tvi_if.sv
// Request and estimate channel interfaces (valid/ready plus payload).
// Depends on tvi_pkg.
`default_nettype none

interface tvi_req_if import tvi_pkg::*;;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [STAMP_W-1:0] stamp;
  comp_t       lin_x;
  comp_t       lin_y;
  comp_t       lin_z;
  comp_t       ang_x;
  comp_t       ang_y;
  comp_t       ang_z;

  modport source (output valid, req_type, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                  input ready);
  modport sink (input valid, req_type, stamp, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                output ready);
endinterface

interface tvi_est_if import tvi_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [STAMP_W-1:0] est_stamp;
  comp_t       est_lin_x;
  comp_t       est_lin_y;
  comp_t       est_lin_z;
  comp_t       est_ang_x;
  comp_t       est_ang_y;
  comp_t       est_ang_z;

  modport source (output valid, status, est_stamp, est_lin_x, est_lin_y, est_lin_z,
                  est_ang_x, est_ang_y, est_ang_z, input ready);
  modport sink (input valid, status, est_stamp, est_lin_x, est_lin_y, est_lin_z,
                est_ang_x, est_ang_y, est_ang_z, output ready);
endinterface

`default_nettype wire

### hw/rtl/timestamped_velocity_interpolator.sv
// Timestamped velocity interpolator.
// Channels: req (sink) carries add and query requests; est (source) carries one
// estimate for every query request and nothing for an add request.
// Samples live in one RAM of DEPTH entries kept sorted by stamp, oldest first.
// An add scans the RAM, reading then comparing each entry, to find its slot, moves
// the entries that must shift (each read, then written back one place), then
// writes the new sample; a full store drops its oldest entry, or the new sample
// if that is older than all. A query scans the same way, then the six scaling
// lanes run a chunked multiply and a bit-serial division in parallel; an answer
// without division (no estimate, held sample, equal newest stamps) skips that
// step.
// One request is in flight at a time; req.ready is high only while idle.
// The estimate sits in an output register; a stalled receiver keeps it there,
// and the block still takes the next request, waiting at its end only if the
// register is still full. Reset empties the store (count to zero) at once;
// RAM contents are never read before being written.
`default_nettype none

module timestamped_velocity_interpolator import tvi_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tvi_req_if.sink   req,
  tvi_est_if.source est
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_ARD   = 12'b000000000010,
    S_ACMP  = 12'b000000000100,
    S_SHSET = 12'b000000001000,
    S_SHRD  = 12'b000000010000,
    S_SHWR  = 12'b000000100000,
    S_INS   = 12'b000001000000,
    S_QRD   = 12'b000010000000,
    S_QCMP  = 12'b000100000000,
    S_CALC  = 12'b001000000000,
    S_WAIT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      wpos;
  logic [CW-1:0]      k;
  logic [STAMP_W-1:0] t;
  comp_t [NCOMP-1:0]  nvel;
  sample_t            ea;
  sample_t            eb;
  logic [1:0]         mode;
  logic               use_q;
  logic               out_valid;

  logic               full;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  sample_t            wdata;
  sample_t            rdata;
  logic [CW-1:0]      k_next;
  logic               more;
  logic [CW-1:0]      wpos_c;
  logic [STAMP_W-1:0] num;
  logic [STAMP_W-1:0] den;
  logic               lane_start;
  logic [NCOMP-1:0]   lane_done;
  logic signed [Q_W-1:0] lane_q [NCOMP];
  logic signed [COMP_W:0] diff [NCOMP];
  comp_t [NCOMP-1:0]  res;
  logic               out_free;

  assign full      = (count == FULL);
  assign req.ready = (state == S_IDLE);
  assign est.valid = out_valid;
  assign out_free  = !out_valid || est.ready;
  assign k_next    = full ? (k + CW'(1)) : (k - CW'(1));
  assign more      = full ? (k_next < wpos) : (k_next > wpos);
  assign wpos_c    = full ? (pos - CW'(1)) : pos;
  assign den       = eb.stamp - ea.stamp;
  assign num       = t - ((mode == ST_EXTRAP) ? eb.stamp : ea.stamp);
  assign lane_start = (state == S_CALC) && (den != '0);

  always_comb begin
    we    = 1'b0;
    waddr = k[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    if (state == S_SHRD) begin
      raddr = full ? AW'(k + CW'(1)) : AW'(k - CW'(1));
    end
    if (state == S_SHWR) begin
      we = 1'b1;
    end
    if (state == S_INS) begin
      we    = 1'b1;
      waddr = wpos[AW-1:0];
      wdata = '{stamp: t, vel: nvel};
    end
  end

  tvi_ram #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  for (genvar j = 0; j < NCOMP; j++) begin : g_lane
    logic signed [COMP_W-1:0] base;
    logic signed [Q_W-1:0]    qx;
    logic signed [SUM_W-1:0]  sum;

    assign diff[j] = $signed({eb.vel[j][COMP_W-1], eb.vel[j]})
                   - $signed({ea.vel[j][COMP_W-1], ea.vel[j]});

    tvi_scale u_scale (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .diff  (diff[j]),
      .num   (num),
      .den   (den),
      .done  (lane_done[j]),
      .q     (lane_q[j])
    );

    always_comb begin
      base = (mode == ST_INTERP) ? ea.vel[j] : eb.vel[j];
      qx   = use_q ? lane_q[j] : '0;
      sum  = SUM_W'(base) + SUM_W'(qx);
      if (sum > SUM_W'(32'sh7fffffff)) begin
        res[j] = 32'sh7fffffff;
      end else if (sum < -SUM_W'(33'sh080000000)) begin
        res[j] = 32'sh80000000;
      end else begin
        res[j] = sum[COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the output state a free register is refilled below instead.
      if (out_valid && est.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            t    <= req.stamp;
            nvel <= {req.ang_z, req.ang_y, req.ang_x, req.lin_z, req.lin_y, req.lin_x};
            idx  <= '0;
            use_q <= 1'b0;
            if (req.req_type == REQ_ADD) begin
              pos   <= '0;
              state <= (count == '0) ? S_SHSET : S_ARD;
            end else if (count == '0) begin
              mode  <= ST_NONE;
              state <= S_OUT;
            end else begin
              state <= S_QRD;
            end
          end
        end
        S_ARD: state <= S_ACMP;
        S_ACMP: begin
          if (rdata.stamp <= t) begin
            if (idx + CW'(1) == count) begin
              pos   <= count;
              state <= S_SHSET;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_ARD;
            end
          end else begin
            pos   <= idx;
            state <= S_SHSET;
          end
        end
        S_SHSET: begin
          wpos <= wpos_c;
          k    <= full ? '0 : count;
          if (full && pos == '0) begin
            state <= S_IDLE;
          end else if (full ? ('0 < wpos_c) : (count > wpos_c)) begin
            state <= S_SHRD;
          end else begin
            state <= S_INS;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          k     <= k_next;
          state <= more ? S_SHRD : S_INS;
        end
        S_INS: begin
          if (!full) begin
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end
        S_QRD: state <= S_QCMP;
        S_QCMP: begin
          if ((idx == '0 && t < rdata.stamp) || t == rdata.stamp) begin
            mode  <= ST_NONE;
            state <= S_OUT;
          end else if (rdata.stamp > t) begin
            eb    <= rdata;
            mode  <= ST_INTERP;
            state <= S_CALC;
          end else if (idx + CW'(1) == count) begin
            eb <= rdata;
            if (count == CW'(1)) begin
              mode  <= ST_HOLD;
              state <= S_OUT;
            end else begin
              mode  <= ST_EXTRAP;
              state <= S_CALC;
            end
          end else begin
            ea    <= rdata;
            idx   <= idx + CW'(1);
            state <= S_QRD;
          end
        end
        S_CALC: begin
          // Equal newest stamps give a zero slope: the newest sample stands.
          if (den == '0) begin
            state <= S_OUT;
          end else begin
            use_q <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (&lane_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            est.status    <= mode;
            est.est_stamp <= t;
            if (mode == ST_NONE) begin
              {est.est_ang_z, est.est_ang_y, est.est_ang_x,
               est.est_lin_z, est.est_lin_y, est.est_lin_x} <= '0;
            end else begin
              {est.est_ang_z, est.est_ang_y, est.est_ang_x,
               est.est_lin_z, est.est_lin_y, est.est_lin_x} <= res;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("sample count above depth");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == S_WAIT)
    else $error("scaling lane finished outside wait state");
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QCMP || state == S_ACMP) |-> idx < count)
    else $error("scan index beyond stored samples");
  a_add_no_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |=> !$rose(out_valid))
    else $error("add request produced an estimate");
`endif

endmodule

`default_nettype wire

### hw/rtl/tvi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/tvi_scale.sv
// One lane of the scaling unit: trunc(diff * num / den), magnitude clamped to 2^40.
// Chunked multiply then bit-serial restoring division. Depends on tvi_pkg.
`default_nettype none

module tvi_scale import tvi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COMP_W:0]   diff,
  input  logic [STAMP_W-1:0]       num,
  input  logic [STAMP_W-1:0]       den,
  output logic                     done,
  output logic signed [Q_W-1:0]    q
);

  localparam int BC_W = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                  state;
  logic                    neg;
  logic [COMP_W:0]         mag;
  logic [STAMP_W-1:0]      num_r;
  logic [STAMP_W-1:0]      den_r;
  logic [1:0]              cnt;
  logic [COMP_W+CHUNK_W:0] prod;
  logic [PROD_W-1:0]       acc;
  logic [PROD_W-1:0]       quo;
  logic [STAMP_W:0]        rem;
  logic [BC_W-1:0]         bitcnt;

  logic [CHUNK_W-1:0]      chunk;
  logic [PROD_W-1:0]       prod_sh;
  logic [STAMP_W:0]        rem_sh;
  logic                    qbit;
  logic [Q_W-2:0]          qmag;

  always_comb begin
    case (cnt)
      2'd0:    chunk = num_r[CHUNK_W-1:0];
      2'd1:    chunk = num_r[2*CHUNK_W-1:CHUNK_W];
      default: chunk = num_r[3*CHUNK_W-1:2*CHUNK_W];
    endcase
    case (cnt)
      2'd1:    prod_sh = PROD_W'(prod);
      2'd2:    prod_sh = PROD_W'(prod) << CHUNK_W;
      default: prod_sh = PROD_W'(prod) << (2 * CHUNK_W);
    endcase
    rem_sh = {rem[STAMP_W-1:0], acc[PROD_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
    if ((|quo[PROD_W-1:Q_W-1]) || (quo[Q_W-2:0] > Q_LIMIT)) begin
      qmag = Q_LIMIT;
    end else begin
      qmag = quo[Q_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= diff[COMP_W];
            mag   <= diff[COMP_W] ? (COMP_W+1)'(-diff) : (COMP_W+1)'(diff);
            num_r <= num;
            den_r <= den;
            cnt   <= 2'd0;
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt != 2'd3) begin
            prod <= mag * chunk;
          end
          if (cnt != 2'd0) begin
            acc <= acc + prod_sh;
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            rem    <= '0;
            quo    <= '0;
            bitcnt <= BC_W'(PROD_W - 1);
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
          quo    <= {quo[PROD_W-2:0], qbit};
          acc    <= acc << 1;
          bitcnt <= bitcnt - BC_W'(1);
          if (bitcnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          q     <= neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
